// ===== src/msgr_pkg.sv =====
// Package for the mode switch gain ramp: payload structs, register codes and
// fixed-point widths. No dependencies.
package msgr_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COUNT_BITS    = 16;
  localparam int GAIN_BITS     = 26;
  localparam int GAIN_FRAC     = 23;
  localparam int RECIP_FRAC    = 24;
  localparam int LEN_BITS      = 16;
  localparam int RECIP_BITS    = 25;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [LEN_BITS-1:0]   RAMP_LENGTH_RESET = LEN_BITS'(139);
  localparam logic [RECIP_BITS-1:0] RAMP_RECIP_RESET  = RECIP_BITS'(120699);

  typedef enum logic {
    ACT_SAMPLE  = 1'b0,
    ACT_REQUEST = 1'b1
  } action_e;

  typedef enum logic {
    REG_RAMP_LENGTH = 1'b0,
    REG_RAMP_RECIP  = 1'b1
  } reg_index_e;

  typedef struct packed {
    action_e                 action;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic                    block_end;
    logic [1:0]              wanted_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] scaled_left;
    logic signed [SAMPLE_BITS-1:0] scaled_right;
    logic                    active_mode;
    logic                    engine_reset;
  } out_item_t;

endpackage

// ===== src/mode_switch_gain_ramp.sv =====
// Flow: a sample beat is taken into the input register when accepted and moves on to the
// result register once that register is empty or being read; mode request beats give no
// result.
// Throughput: one beat per cycle while the output is not stalled, set by the combinational gain and step update.
// Reset: gains and steps clear to zero, so output is silent until the first block
// end, after which the gains ramp up to one. Ramp registers take their defaults.
// Depends on msgr_pkg.
module mode_switch_gain_ramp
  import msgr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_item_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int SPW = SAMPLE_BITS + GAIN_BITS;      // sample times gain
  localparam int SRW = SPW - GAIN_FRAC;              // after rounding shift
  localparam int DW  = GAIN_BITS + 1;                // goal minus gain
  localparam int RPW = DW + RECIP_BITS + 1;          // diff times reciprocal
  localparam int RSW = RPW - RECIP_FRAC;             // after rounding shift
  localparam int CW  = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

  localparam logic signed [SPW-1:0] SMP_RND  = SPW'(1) << (GAIN_FRAC - 1);
  localparam logic signed [RPW-1:0] STEP_RND = RPW'(1) << (RECIP_FRAC - 1);

  function automatic logic signed [GAIN_BITS-1:0] sat_gain(
    input logic signed [GAIN_BITS:0] x
  );
    if (x[GAIN_BITS] != x[GAIN_BITS-1]) begin
      return x[GAIN_BITS] ? {1'b1, {(GAIN_BITS-1){1'b0}}} : {1'b0, {(GAIN_BITS-1){1'b1}}};
    end
    return x[GAIN_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SRW-1:0] x
  );
    logic [SRW-SAMPLE_BITS:0] top;
    top = x[SRW-1:SAMPLE_BITS-1];
    if (!((&top) || !(|top))) begin
      return x[SRW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return x[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [GAIN_BITS-1:0] sat_step(
    input logic signed [RSW-1:0] x
  );
    logic [RSW-GAIN_BITS:0] top;
    top = x[RSW-1:GAIN_BITS-1];
    if (!((&top) || !(|top))) begin
      return x[RSW-1] ? {1'b1, {(GAIN_BITS-1){1'b0}}} : {1'b0, {(GAIN_BITS-1){1'b1}}};
    end
    return x[GAIN_BITS-1:0];
  endfunction

  // Configuration registers
  logic [LEN_BITS-1:0]   ramp_length_q;
  logic [RECIP_BITS-1:0] ramp_recip_q;
  reg_index_e            reg_sel;

  // Input and result registers
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t out_item_d;

  // Ramp state
  logic signed [GAIN_BITS-1:0] gain_now_q  [2];
  logic signed [GAIN_BITS-1:0] gain_step_q [2];
  logic                        gain_goal_q;
  logic [COUNT_BITS-1:0]       ramp_count_q;
  logic                        ramp_done_q;
  logic                        switch_pending_q;
  logic                        requested_mode_q;
  logic                        current_mode_q;

  // Datapath
  logic                        advance;
  logic                        is_req;
  logic                        req_take;
  logic                        ramping;
  logic                        snap;
  logic                        done_new;
  logic                        do_switch;
  logic                        goal_bit;
  logic [COUNT_BITS-1:0]       count_next;
  logic signed [GAIN_BITS-1:0] goal_gain;
  logic signed [SAMPLE_BITS-1:0] smp      [2];
  logic signed [GAIN_BITS-1:0] gain_sum   [2];
  logic signed [GAIN_BITS-1:0] gain_new   [2];
  logic signed [SPW-1:0]       smp_prod   [2];
  logic signed [SPW-1:0]       smp_rnd    [2];
  logic signed [SAMPLE_BITS-1:0] scaled   [2];
  logic signed [GAIN_BITS-1:0] step_base  [2];
  logic signed [GAIN_BITS-1:0] step_from  [2];
  logic signed [DW-1:0]        step_diff  [2];
  logic signed [RPW-1:0]       step_prod  [2];
  logic signed [RPW-1:0]       step_rnd   [2];
  logic signed [GAIN_BITS-1:0] step_new   [2];
  logic signed [DW-1:0]        goal_wide;
  logic signed [RECIP_BITS:0]  recip_s;

  // APB port: the word address picks the register.
  assign pready  = 1'b1;
  assign reg_sel = reg_index_e'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_RAMP_LENGTH: prdata = APB_DATA_BITS'(ramp_length_q);
      REG_RAMP_RECIP:  prdata = APB_DATA_BITS'(ramp_recip_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_length_q <= RAMP_LENGTH_RESET;
      ramp_recip_q  <= RAMP_RECIP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_RAMP_LENGTH: ramp_length_q <= pwdata[LEN_BITS-1:0];
        REG_RAMP_RECIP:  ramp_recip_q  <= pwdata[RECIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: a request beat never needs the result register.
  assign is_req      = (in_item_q.action == ACT_REQUEST);
  assign advance     = in_valid_q && (is_req || !out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    req_take   = is_req && !in_item_q.wanted_mode[1]
                 && (in_item_q.wanted_mode[0] != requested_mode_q);
    ramping    = switch_pending_q || !ramp_done_q;
    snap       = CW'(ramp_count_q) >= CW'(ramp_length_q);
    done_new   = ramp_done_q || snap;
    count_next = (ramp_count_q != {COUNT_BITS{1'b1}}) ? ramp_count_q + 1'b1 : ramp_count_q;
    goal_gain  = $signed({2'b00, gain_goal_q, {GAIN_FRAC{1'b0}}});
    do_switch  = !is_req && ramping && in_item_q.block_end && done_new && switch_pending_q;
    // A request ramps toward zero, a mode switch back toward one.
    goal_bit   = !is_req;
    goal_wide  = $signed({{(DW-GAIN_FRAC-1){1'b0}}, goal_bit, {GAIN_FRAC{1'b0}}});
    recip_s    = $signed({1'b0, ramp_recip_q});
    smp[0]     = in_item_q.sample_left;
    smp[1]     = in_item_q.sample_right;

    for (int k = 0; k < 2; k++) begin
      gain_sum[k] = sat_gain({gain_now_q[k][GAIN_BITS-1], gain_now_q[k]}
                             + {gain_step_q[k][GAIN_BITS-1], gain_step_q[k]});
      gain_new[k] = snap ? goal_gain : gain_sum[k];

      smp_prod[k] = smp[k] * gain_new[k];
      smp_rnd[k]  = (smp_prod[k] + SMP_RND) >>> GAIN_FRAC;
      scaled[k]   = sat_sample(smp_rnd[k][SRW-1:0]);

      // The new step starts from the gain one step beyond the present one.
      step_base[k] = is_req ? gain_now_q[k] : gain_new[k];
      step_from[k] = sat_gain({step_base[k][GAIN_BITS-1], step_base[k]}
                              + {gain_step_q[k][GAIN_BITS-1], gain_step_q[k]});
      step_diff[k] = goal_wide - {step_from[k][GAIN_BITS-1], step_from[k]};
      step_prod[k] = step_diff[k] * recip_s;
      step_rnd[k]  = (step_prod[k] + STEP_RND) >>> RECIP_FRAC;
      step_new[k]  = sat_step(step_rnd[k][RSW-1:0]);
    end

    out_item_d.scaled_left  = ramping ? scaled[0] : in_item_q.sample_left;
    out_item_d.scaled_right = ramping ? scaled[1] : in_item_q.sample_right;
    out_item_d.active_mode  = do_switch ? requested_mode_q : current_mode_q;
    out_item_d.engine_reset = do_switch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance && !is_req) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (advance && !is_req) begin
      out_item_q <= out_item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_now_q[0]    <= '0;
      gain_now_q[1]    <= '0;
      gain_step_q[0]   <= '0;
      gain_step_q[1]   <= '0;
      gain_goal_q      <= 1'b0;
      ramp_count_q     <= '0;
      ramp_done_q      <= 1'b1;
      switch_pending_q <= 1'b1;
      requested_mode_q <= 1'b0;
      current_mode_q   <= 1'b0;
    end else if (advance) begin
      if (is_req) begin
        if (req_take) begin
          requested_mode_q <= in_item_q.wanted_mode[0];
          switch_pending_q <= 1'b1;
          gain_step_q[0]   <= step_new[0];
          gain_step_q[1]   <= step_new[1];
          gain_goal_q      <= 1'b0;
          ramp_count_q     <= '0;
          ramp_done_q      <= 1'b0;
        end
      end else if (ramping) begin
        gain_now_q[0] <= gain_new[0];
        gain_now_q[1] <= gain_new[1];
        if (do_switch) begin
          gain_step_q[0]   <= step_new[0];
          gain_step_q[1]   <= step_new[1];
          gain_goal_q      <= 1'b1;
          ramp_count_q     <= '0;
          ramp_done_q      <= 1'b0;
          switch_pending_q <= 1'b0;
          current_mode_q   <= requested_mode_q;
        end else begin
          ramp_count_q <= count_next;
          ramp_done_q  <= done_new;
        end
      end
    end
  end

endmodule

// ===== sim/msgr_checker.sv =====
// Checker for the mode switch gain ramp: watches the sample channels and the APB
// writes, predicts every scaled output beat and compares it with the block.
// Depends on msgr_pkg.
module msgr_checker
  import msgr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  in_item_t                 in_item_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  out_item_t                out_item_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic [APB_ADDR_BITS-1:0] paddr_i,
  input  logic [APB_DATA_BITS-1:0] pwdata_i,
  input  logic                     pready_i,
  output int                       outstanding_o,
  output int                       fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LEN_BITS-1:0]          len_cfg;
  logic [RECIP_BITS-1:0]        recip_cfg;
  logic signed [GAIN_BITS-1:0]  gain_now [2];
  logic signed [GAIN_BITS-1:0]  gain_step [2];
  logic                         gain_goal;
  logic [COUNT_BITS-1:0]        ramp_count;
  logic                         ramp_done;
  logic                         switch_pending;
  logic                         requested_mode;
  logic                         current_mode;

  out_item_t scaled_q [$];
  int        backlog = 0;
  int        mism_count = 0;

  assign outstanding_o = backlog;
  assign fail_count_o  = mism_count;

  function automatic longint clip(input longint x, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (x > hi) ? hi : ((x < lo) ? lo : x);
  endfunction

  // Floor of (x + half) / 2^s, that is rounding half toward plus infinity.
  function automatic longint round_q(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // The step is aimed from the gain the next sample would see, not the present one.
  task automatic start_ramp(input logic goal);
    for (int k = 0; k < 2; k++) begin
      longint nxt;
      longint diff;
      nxt  = clip(longint'(gain_now[k]) + longint'(gain_step[k]), GAIN_BITS);
      diff = (longint'(goal) <<< GAIN_FRAC) - nxt;
      gain_step[k] = GAIN_BITS'(clip(round_q(diff * longint'(recip_cfg), RECIP_FRAC),
                                     GAIN_BITS));
    end
    gain_goal  = goal;
    ramp_count = '0;
    ramp_done  = 1'b0;
  endtask

  task automatic crossfade_step(input in_item_t beat);
    longint    smp [2];
    logic      pulse;
    out_item_t res;
    pulse = 1'b0;
    if (beat.action == ACT_REQUEST) begin
      if (beat.wanted_mode <= 2'd1 && beat.wanted_mode[0] != requested_mode) begin
        requested_mode = beat.wanted_mode[0];
        switch_pending = 1'b1;
        start_ramp(1'b0);
      end
    end else begin
      smp[0] = longint'($signed(beat.sample_left));
      smp[1] = longint'($signed(beat.sample_right));
      if (switch_pending || !ramp_done) begin
        for (int k = 0; k < 2; k++) begin
          gain_now[k] = GAIN_BITS'(clip(longint'(gain_now[k]) + longint'(gain_step[k]),
                                        GAIN_BITS));
        end
        if (ramp_count >= len_cfg) begin
          gain_now[0] = GAIN_BITS'(longint'(gain_goal) <<< GAIN_FRAC);
          gain_now[1] = GAIN_BITS'(longint'(gain_goal) <<< GAIN_FRAC);
          ramp_done   = 1'b1;
        end
        if (ramp_count != '1) ramp_count++;
        for (int k = 0; k < 2; k++) begin
          smp[k] = clip(round_q(smp[k] * longint'(gain_now[k]), GAIN_FRAC), SAMPLE_BITS);
        end
        if (beat.block_end && ramp_done && switch_pending) begin
          start_ramp(1'b1);
          switch_pending = 1'b0;
          current_mode   = requested_mode;
          pulse          = 1'b1;
        end
      end
      res.scaled_left  = SAMPLE_BITS'(smp[0]);
      res.scaled_right = SAMPLE_BITS'(smp[1]);
      res.active_mode  = current_mode;
      res.engine_reset = pulse;
      scaled_q.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mism_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      len_cfg        = RAMP_LENGTH_RESET;
      recip_cfg      = RAMP_RECIP_RESET;
      gain_now[0]    = '0;
      gain_now[1]    = '0;
      gain_step[0]   = '0;
      gain_step[1]   = '0;
      gain_goal      = 1'b0;
      ramp_count     = '0;
      ramp_done      = 1'b1;
      switch_pending = 1'b1;
      requested_mode = 1'b0;
      current_mode   = 1'b0;
      scaled_q.delete();
      backlog        = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_index_e'(paddr_i[2]))
          REG_RAMP_LENGTH: len_cfg   = pwdata_i[LEN_BITS-1:0];
          REG_RAMP_RECIP:  recip_cfg = pwdata_i[RECIP_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) crossfade_step(in_item_i);
      if (out_valid_i && out_ready_i) begin
        if (scaled_q.size() == 0) begin
          $display("%0t: output beat with none expected, actual %h", $time, out_item_i);
          mism_count++;
        end else begin
          want = scaled_q.pop_front();
          check_field("scaled_left", $signed(want.scaled_left),
                      $signed(out_item_i.scaled_left));
          check_field("scaled_right", $signed(want.scaled_right),
                      $signed(out_item_i.scaled_right));
          check_field("active_mode", want.active_mode, out_item_i.active_mode);
          check_field("engine_reset", want.engine_reset, out_item_i.engine_reset);
        end
      end
      backlog = scaled_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Top of the mode switch gain ramp testbench: clock, reset, APB register writes,
// sample and request stimulus with random idling, and the verdict.
// Depends on msgr_pkg, mode_switch_gain_ramp and msgr_checker.
module tb;
  import msgr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int DRAIN_CYCLES      = 8;
  localparam int LONG_HOLD         = 300;
  localparam int RANDOM_BEATS      = 110;
  localparam int RANDOM_PHASES     = 6;
  localparam int LONG_RAMP_BEATS   = 24;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_item_t                 in_item = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_item;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int outstanding;
  int fail_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  mode_switch_gain_ramp i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  msgr_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // A long hold is counted here so that the sender keeps offering beats meanwhile.
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_left = LONG_HOLD;
      hold_seen = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(15))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic in_item_t random_beat();
    in_item_t b;
    b.action       = ($urandom_range(99) < 5) ? ACT_REQUEST : ACT_SAMPLE;
    b.sample_left  = random_sample();
    b.sample_right = random_sample();
    b.block_end    = ($urandom_range(7) == 0);
    b.wanted_mode  = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
    return b;
  endfunction

  function automatic in_item_t sample_beat(input logic signed [SAMPLE_BITS-1:0] left,
                                           input logic signed [SAMPLE_BITS-1:0] right,
                                           input logic last);
    in_item_t b;
    b = random_beat();
    b.action       = ACT_SAMPLE;
    b.sample_left  = left;
    b.sample_right = right;
    b.block_end    = last;
    return b;
  endfunction

  function automatic in_item_t request_beat(input logic [1:0] mode);
    in_item_t b;
    b = random_beat();
    b.action      = ACT_REQUEST;
    b.wanted_mode = mode;
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input in_item_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(4 * int'(idx));
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Extra cycles cover a request still inside the pipeline, which leaves no result.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_idling(input int sel);
    case (sel)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  initial begin
    int       len;
    int       recip;
    in_item_t beat;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short ramps so that a whole switch fits into a handful of beats.
    write_reg(REG_RAMP_LENGTH, 4);
    write_reg(REG_RAMP_RECIP, 1 << 22);
    set_idling(3);
    send_beat(sample_beat(S_MAX, S_MIN, 1'b0));
    send_beat(sample_beat(S_MIN, S_MAX, 1'b1));
    repeat (6) send_beat(sample_beat(S_MAX, S_MIN, 1'b0));
    send_beat(sample_beat(S_MIN, S_MAX, 1'b0));
    send_beat(sample_beat('0, '1, 1'b0));
    send_beat(request_beat(2'd2));
    send_beat(request_beat(2'd3));
    send_beat(request_beat(2'd0));
    send_beat(request_beat(2'd1));
    send_beat(sample_beat(S_MAX, S_MAX, 1'b1));
    send_beat(sample_beat(S_MIN, S_MIN, 1'b0));
    send_beat(request_beat(2'd0));
    send_beat(request_beat(2'd1));
    repeat (6) send_beat(sample_beat(S_MAX, S_MIN, 1'b0));
    send_beat(sample_beat(S_MAX, S_MIN, 1'b1));
    send_beat(sample_beat('1, 24'sd1, 1'b0));

    // A zero ramp length snaps the gain on the first beat of each ramp.
    drain(DRAIN_CYCLES);
    write_reg(REG_RAMP_LENGTH, 0);
    write_reg(REG_RAMP_RECIP, 0);
    send_beat(request_beat(2'd0));
    send_beat(sample_beat(S_MAX, S_MIN, 1'b0));
    send_beat(sample_beat(S_MIN, S_MAX, 1'b1));
    send_beat(sample_beat(S_MAX, S_MIN, 1'b0));
    send_beat(sample_beat(S_MIN, S_MAX, 1'b0));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain(DRAIN_CYCLES);
      case (ph)
        0: begin len = 1;   recip = 1 << 24; end
        1: begin len = 139; recip = 120699;  end
        2: begin len = 3;   recip = 5592405; end
        3: begin len = $urandom_range(20, 2); recip = $urandom_range(1 << 24); end
        4: begin len = 0;   recip = 0;       end
        default: begin len = $urandom_range(12, 5); recip = (1 << 24) / len; end
      endcase
      write_reg(REG_RAMP_LENGTH, len);
      write_reg(REG_RAMP_RECIP, recip);
      set_idling(ph % 4);
      if (ph == 0) hold_req = 1'b1;
      repeat (RANDOM_BEATS) send_beat(random_beat());
    end

    // The longest ramp keeps the gain moving in small steps for the whole tail.
    drain(DRAIN_CYCLES);
    write_reg(REG_RAMP_LENGTH, 65535);
    write_reg(REG_RAMP_RECIP, 256);
    set_idling(0);
    send_beat(request_beat(2'd0));
    send_beat(request_beat(2'd1));
    repeat (LONG_RAMP_BEATS) begin
      beat = random_beat();
      beat.action = ACT_SAMPLE;
      send_beat(beat);
    end

    drain(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
